@@ rtl/gcst_pkg.sv @@
// ----------------------------------------------------------------------------
// gcst_pkg
// Shared types, widths and constants of the Gaussian charge source term block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcst_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int VAR_W   = 32;
    localparam int COV_W   = 33;
    localparam int DET_W   = 64;
    localparam int NQ_W    = 98;   // quadratic form numerator
    localparam int H_W     = 38;   // q/2 in Q6.32, clamp at 64.0
    localparam int E_W     = 33;   // exp term, Q0.32 up to 1.0
    localparam int IDX_W   = 3;

    // pipeline depth per unit
    localparam int QUAD_STAGES = 6;
    localparam int DIV_STAGES  = H_W;
    localparam int EXP_STAGES  = 13;
    localparam int LATENCY     = QUAD_STAGES + DIV_STAGES + EXP_STAGES;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_VAR_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_VAR_Y    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COV_XY   = 3'd4;

    // reset values
    localparam logic [VAR_W-1:0] VAR_RESET = 32'd4294967;
    localparam logic [COV_W-1:0] COV_RESET = 33'd2147484;

    // arithmetic constants
    localparam logic [95:0] N8_DIVIDEND = 96'd1178016388520346 << 45;  // 1/(2 pi eps0) Q.16
    localparam logic [32:0] LOG2E_Q32   = 33'd6196328019;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] DIV5_MAGIC  = 32'hCCCC_CCCD;  // >> 34
    localparam logic [31:0] DIV3_MAGIC  = 32'hAAAA_AAAB;  // >> 33

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic [63:0] source_term;
        logic        singular;
    } result_t;

    // configuration and derived values seen by the datapath
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [VAR_W-1:0]          var_x;
        logic [VAR_W-1:0]          var_y;
        logic [31:0]               cmag;
        logic                      cneg;
        logic [DET_W-1:0]          det;
        logic [63:0]               n8;
        logic                      singular;
    } cfg_t;

    // quadratic form handed to the divider
    typedef struct packed {
        logic             far;
        logic [63:0]      rem;
        logic [H_W-1:0]   low;
    } div_req_t;

    // divider result
    typedef struct packed {
        logic             far;
        logic [H_W-1:0]   h;
    } half_q_t;

    // 2^(-j/8) in Q0.32
    function automatic logic [32:0] exp2_frac(input logic [2:0] j);
        logic [32:0] v;
        case (j)
            3'd0:    v = 33'd4294967296;
            3'd1:    v = 33'd3938502376;
            3'd2:    v = 33'd3611622603;
            3'd3:    v = 33'd3311872529;
            3'd4:    v = 33'd3037000500;
            3'd5:    v = 33'd2784941738;
            3'd6:    v = 33'd2553802834;
            3'd7:    v = 33'd2341847524;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gcst_config.sv @@
// ----------------------------------------------------------------------------
// gcst_config
// Configuration registers and the sequencer that derives det, sqrt and the
// normalization from them (restoring sqrt, then restoring division).
// ----------------------------------------------------------------------------
`default_nettype none

module gcst_config (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gcst_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [gcst_pkg::COV_W-1:0]  cfg_data,
    output logic                             busy,
    output gcst_pkg::cfg_t                   cfg
);

    localparam logic [2:0] ST_DET  = 3'd0;
    localparam logic [2:0] ST_SUB  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_IDLE = 3'd4;

    logic signed [31:0] center_x_reg, center_y_reg;
    logic [31:0]        var_x_reg, var_y_reg;
    logic [32:0]        cov_xy_reg;
    logic [32:0]        cmag;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] csq_reg, csq_next;
    logic        big_reg, big_next;
    logic [63:0] det_reg, det_next;
    logic        sing_reg, sing_next;
    logic [63:0] dshift_reg, dshift_next;
    logic [64:0] rem_reg, rem_next;     // sqrt remainder reaches 2*root
    logic [63:0] root_reg, root_next;
    logic [95:0] num_reg, num_next;
    logic [63:0] quo_reg, quo_next;

    logic [66:0] sq_tmp, sq_trial;
    logic [64:0] dv_tmp;

    // register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            var_x_reg    <= gcst_pkg::VAR_RESET;
            var_y_reg    <= gcst_pkg::VAR_RESET;
            cov_xy_reg   <= gcst_pkg::COV_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                gcst_pkg::REG_CENTER_X: center_x_reg <= cfg_data[31:0];
                gcst_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[31:0];
                gcst_pkg::REG_VAR_X:    var_x_reg    <= cfg_data[31:0];
                gcst_pkg::REG_VAR_Y:    var_y_reg    <= cfg_data[31:0];
                gcst_pkg::REG_COV_XY:   cov_xy_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cmag = cov_xy_reg[32] ? (~cov_xy_reg + 33'd1) : cov_xy_reg;

    // sqrt and division steps
    assign sq_tmp   = {rem_reg, dshift_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign dv_tmp   = {rem_reg[63:0], num_reg[95]};

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        csq_next    = csq_reg;
        big_next    = big_reg;
        det_next    = det_reg;
        sing_next   = sing_reg;
        dshift_next = dshift_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        case (state_reg)
            ST_DET: begin
                prod_next  = var_x_reg * var_y_reg;
                csq_next   = cmag[31:0] * cmag[31:0];
                big_next   = cmag[32];
                state_next = ST_SUB;
            end
            ST_SUB: begin
                det_next    = prod_reg - csq_reg;
                sing_next   = big_reg | (prod_reg <= csq_reg);
                dshift_next = prod_reg - csq_reg;
                rem_next    = '0;
                root_next   = '0;
                cnt_next    = 7'd63;
                state_next  = ST_SQRT;
            end
            ST_SQRT: begin
                dshift_next = {dshift_reg[61:0], 2'b00};
                if (sq_tmp >= sq_trial) begin
                    rem_next  = 65'(sq_tmp - sq_trial);
                    root_next = {root_reg[62:0], 1'b1};
                end else begin
                    rem_next  = sq_tmp[64:0];
                    root_next = {root_reg[62:0], 1'b0};
                end
                if (cnt_reg == 7'd0) begin
                    rem_next   = '0;
                    num_next   = gcst_pkg::N8_DIVIDEND;
                    quo_next   = '0;
                    cnt_next   = 7'd95;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            ST_DIV: begin
                num_next = {num_reg[94:0], 1'b0};
                if (dv_tmp >= {1'b0, root_reg}) begin
                    rem_next = dv_tmp - {1'b0, root_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = dv_tmp;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                if (cnt_reg == 7'd0) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            ST_IDLE: ;
            default: state_next = ST_DET;
        endcase
        // any write restarts the derivation
        if (cfg_we) begin
            state_next = ST_DET;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_DET;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg   <= prod_next;
        csq_reg    <= csq_next;
        big_reg    <= big_next;
        det_reg    <= det_next;
        sing_reg   <= sing_next;
        dshift_reg <= dshift_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
    end

    assign busy = (state_reg != ST_IDLE);

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.var_x    = var_x_reg;
    assign cfg.var_y    = var_y_reg;
    assign cfg.cmag     = cmag[31:0];
    assign cfg.cneg     = cov_xy_reg[32];
    assign cfg.det      = det_reg;
    assign cfg.n8       = quo_reg;
    assign cfg.singular = sing_reg;

endmodule

`default_nettype wire

@@ rtl/gcst_quad.sv @@
// ----------------------------------------------------------------------------
// gcst_quad
// Six-stage pipeline: deltas, squares, partial products, quadratic form and
// the leading partial remainder of q/2 = M * 2^(63-2F) / det.
// ----------------------------------------------------------------------------
`default_nettype none

module gcst_quad #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire gcst_pkg::point_t  point,
    input  wire gcst_pkg::cfg_t    cfg,
    output logic                   out_valid,
    output gcst_pkg::div_req_t     out_req
);

    localparam int SH  = 63 - 2 * COORD_FRAC_BITS;
    localparam int NW  = gcst_pkg::NQ_W + SH;
    localparam int HIW = NW - gcst_pkg::H_W;
    localparam int CW  = HIW + 64;

    logic [5:0] v_reg;

    // stage 1: deltas as magnitude and sign
    logic [32:0] dx, dy, ndx, ndy;
    logic [31:0] ax_reg, ay_reg;
    logic        s1_neg_reg;

    assign dx  = {point.point_x[31], point.point_x} - {cfg.center_x[31], cfg.center_x};
    assign dy  = {point.point_y[31], point.point_y} - {cfg.center_y[31], cfg.center_y};
    assign ndx = ~dx + 33'd1;
    assign ndy = ~dy + 33'd1;

    always_ff @(posedge clk) begin
        ax_reg     <= dx[32] ? ndx[31:0] : dx[31:0];
        ay_reg     <= dy[32] ? ndy[31:0] : dy[31:0];
        s1_neg_reg <= cfg.cneg ^ dx[32] ^ dy[32];
    end

    // stage 2: squares and cross product
    logic [63:0] ax2_reg, ay2_reg, axy_reg;
    logic        s2_neg_reg;

    always_ff @(posedge clk) begin
        ax2_reg    <= 64'(ax_reg) * 64'(ax_reg);
        ay2_reg    <= 64'(ay_reg) * 64'(ay_reg);
        axy_reg    <= 64'(ax_reg) * 64'(ay_reg);
        s2_neg_reg <= s1_neg_reg;
    end

    // stage 3: 32x32 partial products
    logic [63:0] px_lo_reg, px_hi_reg, py_lo_reg, py_hi_reg, pc_lo_reg, pc_hi_reg;
    logic        s3_neg_reg;

    always_ff @(posedge clk) begin
        px_lo_reg  <= 64'(cfg.var_y) * 64'(ax2_reg[31:0]);
        px_hi_reg  <= 64'(cfg.var_y) * 64'(ax2_reg[63:32]);
        py_lo_reg  <= 64'(cfg.var_x) * 64'(ay2_reg[31:0]);
        py_hi_reg  <= 64'(cfg.var_x) * 64'(ay2_reg[63:32]);
        pc_lo_reg  <= 64'(cfg.cmag)  * 64'(axy_reg[31:0]);
        pc_hi_reg  <= 64'(cfg.cmag)  * 64'(axy_reg[63:32]);
        s3_neg_reg <= s2_neg_reg;
    end

    // stage 4: join partial products
    logic [95:0] tx_reg, ty_reg, tc_reg;
    logic        s4_neg_reg;

    always_ff @(posedge clk) begin
        tx_reg     <= {px_hi_reg, 32'b0} + 96'(px_lo_reg);
        ty_reg     <= {py_hi_reg, 32'b0} + 96'(py_lo_reg);
        tc_reg     <= {pc_hi_reg, 32'b0} + 96'(pc_lo_reg);
        s4_neg_reg <= s3_neg_reg;
    end

    // stage 5: M = vy dx^2 + vx dy^2 -/+ 2 |c| |dx dy|
    logic [gcst_pkg::NQ_W-1:0] sum_q, cr_q, nq_reg;

    assign sum_q = gcst_pkg::NQ_W'(tx_reg) + gcst_pkg::NQ_W'(ty_reg);
    assign cr_q  = gcst_pkg::NQ_W'({tc_reg, 1'b0});

    always_ff @(posedge clk) begin
        nq_reg <= s4_neg_reg ? (sum_q + cr_q) : (sum_q - cr_q);
    end

    // stage 6: far test and leading remainder
    logic [NW-1:0]  nwide;
    logic [HIW-1:0] nhi;
    logic [CW-1:0]  nhi_ext, det_ext;
    gcst_pkg::div_req_t req_reg;

    assign nwide   = {nq_reg, {SH{1'b0}}};
    assign nhi     = nwide[NW-1:gcst_pkg::H_W];
    assign nhi_ext = CW'(nhi);
    assign det_ext = CW'(cfg.det);

    always_ff @(posedge clk) begin
        req_reg.far <= (nhi_ext >= det_ext);
        req_reg.rem <= nhi_ext[63:0];
        req_reg.low <= nwide[gcst_pkg::H_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    assign out_valid = v_reg[5];
    assign out_req   = req_reg;

endmodule

`default_nettype wire

@@ rtl/gcst_div.sv @@
// ----------------------------------------------------------------------------
// gcst_div
// Pipelined restoring divider: one quotient bit of q/2 per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcst_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire gcst_pkg::div_req_t          in_req,
    input  wire logic [gcst_pkg::DET_W-1:0]  det,
    output logic                             out_valid,
    output gcst_pkg::half_q_t                out_h
);

    localparam int N = gcst_pkg::H_W;

    logic         v_reg   [N];
    logic         far_reg [N];
    logic [63:0]  rem_reg [N];
    logic [N-1:0] low_reg [N];
    logic [N-1:0] q_reg   [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic         v_in, far_in;
        logic [63:0]  rem_in;
        logic [N-1:0] low_in, q_in;
        logic [64:0]  trial;
        logic         ge;
        logic [64:0]  diff;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign far_in = in_req.far;
            assign rem_in = in_req.rem;
            assign low_in = in_req.low;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign far_in = far_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign trial = {rem_in, low_in[N-1]};
        assign ge    = (trial >= {1'b0, det});
        assign diff  = trial - {1'b0, det};

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            far_reg[k] <= far_in;
            rem_reg[k] <= ge ? diff[63:0] : trial[63:0];
            low_reg[k] <= {low_in[N-2:0], 1'b0};
            q_reg[k]   <= {q_in[N-2:0], ge};
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_h.far = far_reg[N-1];
    assign out_h.h   = q_reg[N-1];

endmodule

`default_nettype wire

@@ rtl/gcst_exp.sv @@
// ----------------------------------------------------------------------------
// gcst_exp
// exp(-h) by 2^-t range reduction and a Horner series, then the scale by the
// normalization with rounding and saturation. Thirteen register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcst_exp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire gcst_pkg::half_q_t  in_h,
    input  wire gcst_pkg::cfg_t     cfg,
    output logic                    strobe,
    output gcst_pkg::result_t       result
);

    logic [gcst_pkg::EXP_STAGES-1:0] v_reg;

    // X1: h * log2(e), split on the 32-bit boundary
    logic [64:0] x1_pl_reg;
    logic [38:0] x1_ph_reg;
    logic        x1_zero_reg;

    always_ff @(posedge clk) begin
        x1_pl_reg   <= 65'(in_h.h[31:0]) * 65'(gcst_pkg::LOG2E_Q32);
        x1_ph_reg   <= 39'(in_h.h[37:32]) * 39'(gcst_pkg::LOG2E_Q32);
        x1_zero_reg <= in_h.far;
    end

    // X2: t = h*log2e in Q.32, split into shift, table index, remainder
    logic [70:0] x2_p;
    logic [5:0]  x2_ip_reg;
    logic [2:0]  x2_j_reg;
    logic [28:0] x2_w_reg;
    logic        x2_zero_reg;

    assign x2_p = {x1_ph_reg, 32'b0} + 71'(x1_pl_reg);

    always_ff @(posedge clk) begin
        x2_ip_reg   <= x2_p[69:64];
        x2_j_reg    <= x2_p[63:61];
        x2_w_reg    <= x2_p[60:32];
        x2_zero_reg <= x1_zero_reg | x2_p[70];
    end

    // sideband carried along the series
    logic [5:0]  ip_reg [7];
    logic [2:0]  j_reg  [7];
    logic        z_reg  [7];
    logic [28:0] x_reg  [6];

    // E1: x = w * ln2
    logic [60:0] e1_p;
    assign e1_p = 61'(x2_w_reg) * 61'(gcst_pkg::LN2_Q32);

    always_ff @(posedge clk) begin
        x_reg[0]  <= e1_p[60:32];
        ip_reg[0] <= x2_ip_reg;
        j_reg[0]  <= x2_j_reg;
        z_reg[0]  <= x2_zero_reg;
        for (int s = 1; s < 6; s++) begin
            x_reg[s] <= x_reg[s-1];
        end
        for (int s = 1; s < 7; s++) begin
            ip_reg[s] <= ip_reg[s-1];
            j_reg[s]  <= j_reg[s-1];
            z_reg[s]  <= z_reg[s-1];
        end
    end

    // E2: x / 5
    logic [60:0] e2_p;
    logic [26:0] q5_reg;
    assign e2_p = 61'(x_reg[0]) * 61'(gcst_pkg::DIV5_MAGIC);
    always_ff @(posedge clk) q5_reg <= e2_p[60:34];

    // E3: a = 1 - x/5, m = x*a
    logic [32:0] a1;
    logic [61:0] e3_p;
    logic [28:0] m1_reg;
    assign a1   = gcst_pkg::ONE_Q32 - 33'(q5_reg);
    assign e3_p = 62'(x_reg[1]) * 62'(a1);
    always_ff @(posedge clk) m1_reg <= e3_p[60:32];

    // E4: a = 1 - m/4, m = x*a
    logic [32:0] a2;
    logic [61:0] e4_p;
    logic [28:0] m2_reg;
    assign a2   = gcst_pkg::ONE_Q32 - 33'(m1_reg[28:2]);
    assign e4_p = 62'(x_reg[2]) * 62'(a2);
    always_ff @(posedge clk) m2_reg <= e4_p[60:32];

    // E5: m / 3
    logic [60:0] e5_p;
    logic [27:0] q3_reg;
    assign e5_p = 61'(m2_reg) * 61'(gcst_pkg::DIV3_MAGIC);
    always_ff @(posedge clk) q3_reg <= e5_p[60:33];

    // E6: a = 1 - m/3, m = x*a
    logic [32:0] a3;
    logic [61:0] e6_p;
    logic [28:0] m3_reg;
    assign a3   = gcst_pkg::ONE_Q32 - 33'(q3_reg);
    assign e6_p = 62'(x_reg[4]) * 62'(a3);
    always_ff @(posedge clk) m3_reg <= e6_p[60:32];

    // E7: a = 1 - m/2, m = x*a
    logic [32:0] a4;
    logic [61:0] e7_p;
    logic [28:0] m4_reg;
    assign a4   = gcst_pkg::ONE_Q32 - 33'(m3_reg[28:1]);
    assign e7_p = 62'(x_reg[5]) * 62'(a4);
    always_ff @(posedge clk) m4_reg <= e7_p[60:32];

    // E8: table entry times series
    logic [32:0] a5;
    logic [65:0] e8_p;
    logic [32:0] pe_reg;
    logic [5:0]  e8_ip_reg;
    logic        e8_z_reg;
    assign a5   = gcst_pkg::ONE_Q32 - 33'(m4_reg);
    assign e8_p = 66'(gcst_pkg::exp2_frac(j_reg[6])) * 66'(a5);
    always_ff @(posedge clk) begin
        pe_reg    <= e8_p[64:32];
        e8_ip_reg <= ip_reg[6];
        e8_z_reg  <= z_reg[6];
    end

    // E9: integer part as right shift
    logic [gcst_pkg::E_W-1:0] e_reg;
    always_ff @(posedge clk) e_reg <= e8_z_reg ? '0 : (pe_reg >> e8_ip_reg);

    // F1: n8 * e as two partial products
    logic [64:0] f1_lo_reg, f1_hi_reg;
    always_ff @(posedge clk) begin
        f1_lo_reg <= 65'(cfg.n8[31:0])  * 65'(e_reg);
        f1_hi_reg <= 65'(cfg.n8[63:32]) * 65'(e_reg);
    end

    // F2: round, saturate, singular override
    logic [97:0] fin;
    gcst_pkg::result_t res_reg;
    assign fin = {f1_hi_reg, 32'b0} + 98'(f1_lo_reg) + 98'(1) * (98'(1) << 28);

    always_ff @(posedge clk) begin
        if (cfg.singular) begin
            res_reg.source_term <= '0;
        end else if (|fin[97:93]) begin
            res_reg.source_term <= '1;
        end else begin
            res_reg.source_term <= fin[92:29];
        end
        res_reg.singular <= cfg.singular;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[gcst_pkg::EXP_STAGES-2:0], in_valid};
        end
    end

    assign strobe = v_reg[gcst_pkg::EXP_STAGES-1];
    assign result = res_reg;

endmodule

`default_nettype wire

@@ rtl/gaussian_charge_source_term.sv @@
// ----------------------------------------------------------------------------
// gaussian_charge_source_term
// Bivariate Gaussian density about a configured center and covariance,
// divided by eps0, one point per clock while busy is low.
// ----------------------------------------------------------------------------
//  channel   ports                                 rule
//  point     start, busy, point                    taken when start && !busy
//  result    strobe, result                        valid for one cycle, no hold
//  config    cfg_we, cfg_index, cfg_data           written when cfg_we
//
//  One point enters per cycle while busy is low; its result passes through
//  6 quadratic-form stages, 38 divider stages and 13 exp and scale stages.
//  After reset and after every register write busy stays high while the
//  sequencer derives det, sqrt(det) bit by bit and the normalization by a
//  96-step division.
//  The pipeline never stalls; results are dropped on the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_charge_source_term #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire gcst_pkg::point_t            point,
    input  wire logic                        cfg_we,
    input  wire logic [gcst_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [gcst_pkg::COV_W-1:0]  cfg_data,
    output logic                             strobe,
    output gcst_pkg::result_t                result
);

    gcst_pkg::cfg_t     cfg;
    gcst_pkg::div_req_t div_req;
    gcst_pkg::half_q_t  half_q;
    logic               accept, quad_valid, div_valid;

    assign accept = start & ~busy;

    gcst_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg       (cfg)
    );

    gcst_quad #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .point     (point),
        .cfg       (cfg),
        .out_valid (quad_valid),
        .out_req   (div_req)
    );

    gcst_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quad_valid),
        .in_req    (div_req),
        .det       (cfg.det),
        .out_valid (div_valid),
        .out_h     (half_q)
    );

    gcst_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_h     (half_q),
        .cfg      (cfg),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ rtl/gcst_checker.sv @@
// ----------------------------------------------------------------------------
// gcst_checker
// Port-level checks of latency, configuration lockout and the singular case.
// ----------------------------------------------------------------------------
`default_nettype none

module gcst_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              cfg_we,
    input wire logic              strobe,
    input wire gcst_pkg::result_t result
);

    // every request comes back after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(gcst_pkg::LATENCY) strobe)
        else $error("request lost in pipeline");

    // no result without a request that long ago
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy, gcst_pkg::LATENCY))
        else $error("result without request");

    // a write locks out requests while derived values are rebuilt
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("not busy after register write");

    // singular covariance gives zero
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.singular) |-> (result.source_term == 64'd0))
        else $error("nonzero result with singular covariance");

endmodule

bind gaussian_charge_source_term gcst_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cfg_we (cfg_we),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

@@ tb/gaussian_charge_source_term_tb.sv @@
// ----------------------------------------------------------------------------
// gaussian_charge_source_term_tb
// Drives 2-D points through the Gaussian source term block under a series of
// center and covariance settings and checks every result against a bit-exact
// fixed-point model of the density held in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gaussian_charge_source_term_tb;

    localparam int          FRAC_BITS   = 24;
    localparam int          Q_SHIFT     = 63 - 2 * FRAC_BITS;
    localparam logic [63:0] HALF_LIMIT  = 64'd64 << 32;
    localparam logic [63:0] KFX_Q16     = 64'd1178016388520346;
    localparam logic [63:0] LOG2E_FX    = 64'd6196328019;
    localparam logic [63:0] LN2_FX      = 64'd2977044472;
    localparam logic [63:0] UNIT_Q32    = 64'h1_0000_0000;
    localparam int          IDLE_LIMIT  = 4000;
    localparam logic [gcst_pkg::IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [gcst_pkg::IDX_W-1:0] REG_SPARE_B = 3'd6;
    localparam logic [gcst_pkg::IDX_W-1:0] REG_SPARE_C = 3'd7;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the settings and the expected density queue
    // ------------------------------------------------------------------------
    class density_board;
        logic signed [31:0] cx, cy;
        logic [31:0]        vx, vy;
        logic [32:0]        cov;
        logic [63:0]        pow2_frac [8];
        gcst_pkg::result_t  pending [$];
        bit                 failed;

        function new();
            cx = '0;
            cy = '0;
            vx = 32'd4294967;
            vy = 32'd4294967;
            cov = 33'd2147484;
            failed = 0;
            pow2_frac = '{64'd4294967296, 64'd3938502376, 64'd3611622603,
                          64'd3311872529, 64'd3037000500, 64'd2784941738,
                          64'd2553802834, 64'd2341847524};
        endfunction

        function void write_reg(logic [gcst_pkg::IDX_W-1:0] idx,
                                logic [gcst_pkg::COV_W-1:0] d);
            case (idx)
                gcst_pkg::REG_CENTER_X: cx = d[31:0];
                gcst_pkg::REG_CENTER_Y: cy = d[31:0];
                gcst_pkg::REG_VAR_X:    vx = d[31:0];
                gcst_pkg::REG_VAR_Y:    vy = d[31:0];
                gcst_pkg::REG_COV_XY:   cov = d;
                default:      ;
            endcase
        endfunction

        // exp(-h), h in Q.32, result in Q0.32
        function logic [63:0] exp_falloff(logic [63:0] h);
            logic [127:0] prod;
            logic [63:0]  t, w, x, a;
            int           ip;
            if (h >= HALF_LIMIT)
                return 64'd0;
            prod = 128'(h) * 128'(LOG2E_FX);
            t = prod[95:32];
            ip = int'(t >> 32);
            if (ip >= 64)
                return 64'd0;
            w = {35'd0, t[28:0]};
            x = (w * LN2_FX) >> 32;
            a = UNIT_Q32 - x / 5;
            a = UNIT_Q32 - ((x * a) >> 32) / 4;
            a = UNIT_Q32 - ((x * a) >> 32) / 3;
            a = UNIT_Q32 - ((x * a) >> 32) / 2;
            a = UNIT_Q32 - ((x * a) >> 32);
            prod = 128'(pow2_frac[t[31:29]]) * 128'(a);
            return prod[95:32] >> ip;
        endfunction

        function gcst_pkg::result_t density(gcst_pkg::point_t p);
            gcst_pkg::result_t  res;
            logic signed [63:0] dx, dy;
            logic [63:0]        ax, ay, cmag, prod, det, h, e, r, n8, c;
            logic [127:0]       sum, cr, nq, sq, fin;
            logic [191:0]       quo;
            bit                 cneg;
            dx = {{32{p.point_x[31]}}, p.point_x} - {{32{cx[31]}}, cx};
            dy = {{32{p.point_y[31]}}, p.point_y} - {{32{cy[31]}}, cy};
            cneg = cov[32];
            cmag = cneg ? 64'(34'h2_0000_0000 - {1'b0, cov}) : 64'(cov);
            prod = 64'(vx) * 64'(vy);
            if (cmag >= UNIT_Q32 || prod <= cmag * cmag) begin
                res.source_term = '0;
                res.singular = 1'b1;
                return res;
            end
            det = prod - cmag * cmag;
            ax = dx < 0 ? 64'(-dx) : 64'(dx);
            ay = dy < 0 ? 64'(-dy) : 64'(dy);
            sum = 128'(vy) * 128'(ax * ax) + 128'(vx) * 128'(ay * ay);
            cr = (128'(cmag) * 128'(ax * ay)) << 1;
            nq = (cneg ^ (dx < 0) ^ (dy < 0)) ? sum + cr : sum - cr;
            // q/2 in Q.32, clamped
            quo = ({64'd0, nq} << Q_SHIFT) / 192'(det);
            h = (quo > 192'(HALF_LIMIT)) ? HALF_LIMIT : quo[63:0];
            e = exp_falloff(h);
            // floor(sqrt(det * 2^64))
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                sq = 128'(c) * 128'(c);
                if (sq <= {det, 64'd0})
                    r = c;
            end
            quo = (192'(KFX_Q16) << 45) / 192'(r);
            n8 = (quo > 192'({64{1'b1}})) ? {64{1'b1}} : quo[63:0];
            fin = 128'(n8) * 128'(e) + (128'd1 << 28);
            res.source_term = (fin >> 93) != 0 ? {64{1'b1}} : fin[92:29];
            res.singular = 1'b0;
            return res;
        endfunction

        function void note_request(gcst_pkg::point_t p);
            pending.push_back(density(p));
        endfunction

        function void check_result(gcst_pkg::result_t got);
            gcst_pkg::result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time, got.source_term,
                         got.singular);
                failed = 1;
                return;
            end
            want = pending.pop_front();
            if (got.source_term !== want.source_term) begin
                $display("%0t: source_term expected %h actual %h", $time,
                         want.source_term, got.source_term);
                failed = 1;
            end
            if (got.singular !== want.singular) begin
                $display("%0t: singular expected %b actual %b", $time,
                         want.singular, got.singular);
                failed = 1;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    gcst_pkg::point_t              point;
    logic                          cfg_we;
    logic [gcst_pkg::IDX_W-1:0]    cfg_index;
    logic [gcst_pkg::COV_W-1:0]    cfg_data;
    logic                          strobe;
    gcst_pkg::result_t             result;
    int                            idle_cycles;
    density_board                  board;

    gaussian_charge_source_term DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitor: accepted requests and results
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(point);
        if (rst_n && strobe)
            board.check_result(result);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request; start stays high when the next one follows directly
    task automatic send_point(logic [31:0] px, logic [31:0] py, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= {px, py};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // wait until every expected result is in and the pipeline is empty
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (gcst_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; caller drops it
    task automatic write_reg(logic [gcst_pkg::IDX_W-1:0] idx,
                             logic [gcst_pkg::COV_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        board.write_reg(idx, d);
    endtask

    task automatic set_gaussian(logic [31:0] cxv, logic [31:0] cyv, logic [31:0] vxv,
                                logic [31:0] vyv, logic [32:0] covv);
        drain();
        write_reg(gcst_pkg::REG_CENTER_X, {cxv[31], cxv});
        write_reg(gcst_pkg::REG_CENTER_Y, {cyv[31], cyv});
        write_reg(gcst_pkg::REG_VAR_X, {1'b0, vxv});
        write_reg(gcst_pkg::REG_VAR_Y, {1'b0, vyv});
        write_reg(gcst_pkg::REG_COV_XY, covv);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_var();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(1, 1 << 12);
            4, 5:    return $urandom_range(1, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_gaussian();
        logic [31:0] vxv, vyv;
        longint      lim, mag;
        vxv = pick_var();
        vyv = pick_var();
        lim = (vxv < vyv) ? longint'(vxv) : longint'(vyv);
        mag = {$urandom, $urandom} % (lim + 1);
        if ($urandom_range(9) == 0)
            mag = {$urandom, $urandom} % 64'h1_0000_0001;
        set_gaussian($urandom_range(3) == 0 ? $urandom : 32'($signed($urandom) >>> 4),
                     $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom) >>> 4),
                     vxv, vyv,
                     $urandom_range(1) ? 33'(mag) : 33'(34'h2_0000_0000 - 34'(mag)));
    endtask

    // coordinate within a few sigma of the center, or anywhere
    function automatic logic [31:0] pick_coord(logic signed [31:0] ctr, logic [31:0] v);
        real    span;
        longint off;
        if ($urandom_range(9) < 3)
            return $urandom;
        span = $sqrt(real'(v)) * 256.0 * 6.0 + 1.0;
        off = longint'(span * (real'($urandom_range(2000)) - 1000.0) / 1000.0);
        return 32'(longint'(ctr) + off);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_pct [4];
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = '{0, 82, 0, 31};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: center, extremes, about two sigma away
        send_point(32'd0, 32'd0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'd1 << 20, 32'd0, 0);
        send_point(32'd0, -(32'd1 << 20), 0);

        // tiny determinant: density saturates; far point gives zero
        set_gaussian(32'd0, 32'd0, 32'd1, 32'd1, 33'd0);
        send_point(32'd0, 32'd0, 0);
        send_point(32'd1 << 24, 32'd1 << 24, 0);

        // singular covariances: |cov| of one, zero variance, cov^2 equal to product
        set_gaussian(32'd0, 32'd0, 32'd4294967, 32'd4294967, 33'h1_0000_0000);
        send_point(32'd0, 32'd0, 0);
        set_gaussian(32'd0, 32'd0, 32'd0, 32'h8000_0000, 33'd0);
        send_point(32'd5, 32'd7, 0);
        set_gaussian(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     33'h0_FFFF_FFFF);
        send_point(32'd0, 32'd0, 0);
        set_gaussian(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     33'h1_0000_0001);
        send_point(32'd0, 32'd0, 0);

        // extreme centers and variances, full distance
        set_gaussian(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(32'h7F00_0000, 32'h8100_0000, 0);

        // writes to unused indexes change nothing
        drain();
        write_reg(REG_SPARE_A, 33'h1_FFFF_FFFF);
        write_reg(REG_SPARE_B, 33'h0_1234_5678);
        write_reg(REG_SPARE_C, 33'h1_0000_0000);
        cfg_we <= 1'b0;
        send_point(32'h7FFF_FF00, 32'h8000_0100, 0);

        // random phases, each with a few settings; pause for a full drain between
        for (int ph = 0; ph < 4; ph++) begin
            for (int s = 0; s < 4; s++) begin
                random_gaussian();
                for (int n = 0; n < 47; n++)
                    send_point(pick_coord(board.cx, board.vx),
                               pick_coord(board.cy, board.vy), idle_pct[ph]);
            end
        end

        drain();
        if (board.failed)
            $display("[FAIL] regression broken");
        else
            $display("[ OK ] regression clean");
        $finish;
    end

endmodule
